// ===== rtl/mrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types and constants of the motor reply deframer: register indexes,
// reply kinds, the command code set and the decoded reply word.
// ----------------------------------------------------------------------------
package mrd_pkg;

   // frame geometry
   localparam int FrameLen = 13;
   localparam int CrcSpan  = 11;
   localparam int DataLen  = 8;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // configuration register indexes
   localparam logic [2:0] REG_HEADER       = 3'd0;
   localparam logic [2:0] REG_CODE_STATUS  = 3'd1;
   localparam logic [2:0] REG_CODE_SPEED   = 3'd2;
   localparam logic [2:0] REG_CODE_POS     = 3'd3;
   localparam logic [2:0] REG_CODE_ANGLE   = 3'd4;
   localparam logic [2:0] REG_CODE_ENCODER = 3'd5;

   // reply kinds
   localparam logic [1:0] KIND_OTHER    = 2'd0;
   localparam logic [1:0] KIND_FEEDBACK = 2'd1;
   localparam logic [1:0] KIND_ANGLE    = 2'd2;
   localparam logic [1:0] KIND_ENCODER  = 2'd3;

   // command codes that select the decoding
   typedef struct packed {
      logic [7:0] status;
      logic [7:0] speed_loop;
      logic [7:0] position_loop;
      logic [7:0] turn_angle;
      logic [7:0] turn_encoder;
   } mrd_codes_type;

   // data bytes of a frame, byte i at [i]
   typedef logic [DataLen-1:0][7:0] mrd_bytes_type;

   // one decoded reply word
   typedef struct packed {
      logic        [5:0]  node_id;
      logic        [7:0]  cmd_code;
      logic        [55:0] payload;
      logic        [1:0]  kind;
      logic signed [7:0]  temperature;
      logic signed [15:0] control_value;
      logic signed [15:0] speed;
      logic signed [15:0] shaft_angle;
      logic signed [31:0] turn_position;
   } mrd_result_type;

endpackage

// ===== rtl/motor_reply_deframer_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_reply_deframer_crc16
// Fixed-length reply deframer: 13-byte window, header/id/length checks and a
// Modbus CRC-16 folded byte by byte in one shared CRC unit.
// ----------------------------------------------------------------------------
// Flow: once the byte that completes the frame is taken, the shared unit folds
// the 11 CRC bytes in turn, the frame is checked, and a passing one is loaded.
// Throughput: a byte that leaves the window short is taken every cycle; a full
// window holds ready low through the CRC pass and the check when rejected, and
// also through the load when accepted, which a waiting reply word stalls.
// Reset clears window, byte count, sequencer and output valid; header and codes take defaults.
// ----------------------------------------------------------------------------
module motor_reply_deframer_crc16 #(
   parameter int MAX_NODE_ID = 32
) (
   input  logic                clock,
   input  logic                reset,
   // received bytes
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   // decoded replies
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [5:0]          rsp_node_id,
   output logic [7:0]          rsp_cmd_code,
   output logic [55:0]         rsp_payload,
   output logic [1:0]          rsp_kind,
   output logic signed [7:0]   rsp_temperature,
   output logic signed [15:0]  rsp_control_value,
   output logic signed [15:0]  rsp_speed,
   output logic signed [15:0]  rsp_shaft_angle,
   output logic signed [31:0]  rsp_turn_position,
   // configuration
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   import mrd_pkg::*;

   localparam logic [7:0] MaxId = 8'(MAX_NODE_ID);
   localparam logic [3:0] LastCrcIdx = 4'(CrcSpan - 1);
   localparam logic [3:0] FullCount  = 4'(FrameLen);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CRC   = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [3:0]     idx_ff, idx_in;
   logic [3:0]     held_ff, held_in;
   logic [7:0]     win_ff [FrameLen];
   logic [7:0]     win_in [FrameLen];
   logic [7:0]     header_ff;
   mrd_codes_type  codes_ff;
   mrd_result_type out_ff, out_in;
   logic           out_valid_ff, out_valid_in;

   logic           accept;
   logic           crc_start;
   logic           crc_step;
   logic [15:0]    crc;
   logic           frame_ok;
   logic           slot_free;
   mrd_bytes_type  data_bytes;
   mrd_result_type decoded;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !out_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff              <= 8'd62;
         codes_ff.status        <= 8'd156;
         codes_ff.speed_loop    <= 8'd162;
         codes_ff.position_loop <= 8'd164;
         codes_ff.turn_angle    <= 8'd146;
         codes_ff.turn_encoder  <= 8'd96;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_HEADER:       header_ff              <= csr_wdata;
            REG_CODE_STATUS:  codes_ff.status        <= csr_wdata;
            REG_CODE_SPEED:   codes_ff.speed_loop    <= csr_wdata;
            REG_CODE_POS:     codes_ff.position_loop <= csr_wdata;
            REG_CODE_ANGLE:   codes_ff.turn_angle    <= csr_wdata;
            REG_CODE_ENCODER: codes_ff.turn_encoder  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shift a new byte into the window
   always_comb begin
      for (int i = 0; i < FrameLen; i++) begin
         win_in[i] = win_ff[i];
      end
      if (accept) begin
         for (int i = 0; i < FrameLen - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[FrameLen-1] = req_rx_byte;
      end
   end

   // frame checks against the finished CRC
   assign frame_ok = (win_ff[0] == header_ff) && (win_ff[1] != 8'd0) &&
                     (win_ff[1] <= MaxId) && (win_ff[2] == 8'(DataLen)) &&
                     (crc == {win_ff[12], win_ff[11]});

   always_comb begin
      for (int i = 0; i < DataLen; i++) begin
         data_bytes[i] = win_ff[i + 3];
      end
   end

   mrd_field_decode u_decode (
      .id_byte (win_ff[1]),
      .data    (data_bytes),
      .codes   (codes_ff),
      .result  (decoded)
   );

   mrd_crc_unit u_crc (
      .clock     (clock),
      .start     (crc_start),
      .step_en   (crc_step),
      .data_byte (win_ff[idx_ff]),
      .crc       (crc)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      crc_start    = 1'b0;
      crc_step     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // count the byte, start the CRC once the window is full
            if (accept) begin
               if (held_ff < FullCount) begin
                  held_in = held_ff + 4'd1;
               end
               if (held_ff >= FullCount - 4'd1) begin
                  state_in  = ST_CRC;
                  idx_in    = '0;
                  crc_start = 1'b1;
               end
            end
         end
         ST_CRC: begin
            crc_step = 1'b1;
            idx_in   = idx_ff + 4'd1;
            if (idx_ff == LastCrcIdx) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // drop a bad window, keep the count so it slides
            if (frame_ok) begin
               held_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (slot_free) begin
               out_in       = decoded;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < FrameLen; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < FrameLen; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_node_id       = out_ff.node_id;
   assign rsp_cmd_code      = out_ff.cmd_code;
   assign rsp_payload       = out_ff.payload;
   assign rsp_kind          = out_ff.kind;
   assign rsp_temperature   = out_ff.temperature;
   assign rsp_control_value = out_ff.control_value;
   assign rsp_speed         = out_ff.speed;
   assign rsp_shaft_angle   = out_ff.shaft_angle;
   assign rsp_turn_position = out_ff.turn_position;

   // byte count saturates at a full window
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FullCount)
      else $error("window byte count out of range");

   // a reply word appears only out of the emit state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("reply word without a checked frame");

   // the CRC pass ends in the check after the last CRC-covered byte
   a_crc_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRC && idx_ff == LastCrcIdx) |=> (state_ff == ST_CHECK))
      else $error("CRC pass did not end in the check");

   // an accepted frame empties the window count
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && frame_ok) |=> (held_ff == 4'd0))
      else $error("accepted frame did not clear the window");

endmodule

// ===== rtl/mrd_crc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_crc_unit
// Shared CRC-16 engine: folds one byte per cycle while stepped into a running remainder
// (Modbus polynomial, reflected), restarted by the sequencer per frame.
// ----------------------------------------------------------------------------
module mrd_crc_unit (
   input  logic        clock,
   input  logic        start,
   input  logic        step_en,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc
);
   import mrd_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // eight bit shifts of one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CrcPoly;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // restart or advance the remainder
   always_comb begin
      crc_in = crc_ff;
      if (start) begin
         crc_in = CrcInit;
      end else if (step_en) begin
         crc_in = crc_byte(crc_ff, data_byte);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

// ===== rtl/mrd_field_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_field_decode
// Builds the reply word from the frame's id and data bytes, choosing the
// field decoding by command code.
// ----------------------------------------------------------------------------
module mrd_field_decode (
   input  logic [7:0]             id_byte,
   input  mrd_pkg::mrd_bytes_type data,
   input  mrd_pkg::mrd_codes_type codes,
   output mrd_pkg::mrd_result_type result
);
   import mrd_pkg::*;

   logic [7:0] cmd;
   logic       is_feedback;
   logic       is_angle;
   logic       is_encoder;

   assign cmd         = data[0];
   assign is_feedback = (cmd == codes.status) || (cmd == codes.speed_loop) ||
                        (cmd == codes.position_loop);
   assign is_angle    = (cmd == codes.turn_angle);
   assign is_encoder  = (cmd == codes.turn_encoder);

   // motor feedback wins, then angle, then encoder
   always_comb begin
      result               = '0;
      result.node_id       = id_byte[5:0];
      result.cmd_code      = cmd;
      result.payload       = data[7:1];
      if (is_feedback) begin
         result.kind          = KIND_FEEDBACK;
         result.temperature   = data[1];
         result.control_value = {data[3], data[2]};
         result.speed         = {data[5], data[4]};
         result.shaft_angle   = {data[7], data[6]};
      end else if (is_angle || is_encoder) begin
         result.kind          = is_angle ? KIND_ANGLE : KIND_ENCODER;
         result.turn_position = {data[7], data[6], data[5], data[4]};
      end
   end

endmodule
